// ===== design/eyxz_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Euler Y-X-Z transform package
// Shared widths, constants, pipeline types and small arithmetic helpers for
// the model and normal matrix generator.
// ----------------------------------------------------------------------------
package eyxz_pkg;

    // Field widths fixed by the transaction format.
    localparam int ANGLE_W = 16;
    localparam int SCALE_W = 16;
    localparam int TRANS_W = 32;
    localparam int ELEM_W  = 32;
    localparam int ROW3_W  = 17;

    // Reciprocal of a Q8.8 scale as signed Q8.16: 2^24 / scale.
    localparam int RECIP_W    = 24;
    localparam int NUM_W      = 25;
    localparam int DEN_W      = 16;
    localparam int DIV_STAGES = 5;
    localparam int DIV_BITS   = NUM_W / DIV_STAGES;

    localparam logic signed [RECIP_W-1:0] RECIP_MAX = 24'sh7FFFFF;
    localparam logic signed [RECIP_W-1:0] RECIP_MIN = 24'sh800000;
    localparam logic [NUM_W-1:0]          NUM_ONE   = 25'h1000000;

    // Pi/2 in unsigned Q30, used to build the quarter-wave table.
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Quadrant codes taken from the top two angle bits.
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // Output column sequence: three scaled rotation columns, translation,
    // then three normal matrix columns.
    localparam logic [2:0] COL_TRANS = 3'd3;
    localparam logic [2:0] COL_NORM0 = 3'd4;
    localparam logic [2:0] COL_LAST  = 3'd6;

    localparam logic [ROW3_W-1:0] ROW3_ONE = 17'd65536;

    // Scale and translation travel alongside the pipeline unchanged.
    typedef struct packed {
        logic [2:0][SCALE_W-1:0] scale;
        logic [2:0][TRANS_W-1:0] trans;
    } t_side;

    // One lane of the restoring reciprocal divider.
    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic [DEN_W-1:0] rem;
        logic [NUM_W-1:0] quo;
        logic             neg;
        logic             zero;
    } t_div;

    // Retire DIV_BITS quotient bits, starting at bit position top.
    function automatic t_div div_step(input t_div d, input int top);
        logic [DEN_W:0] acc;
        t_div           o;
        o = d;
        for (int b = 0; b < DIV_BITS; b++) begin
            acc = {o.rem, o.num[top-b]};
            if (acc >= {1'b0, o.den}) begin
                acc            = acc - {1'b0, o.den};
                o.quo[top-b]   = 1'b1;
            end
            o.rem = acc[DEN_W-1:0];
        end
        return o;
    endfunction

    // Clamp a wide signed value to the 32-bit element range.
    function automatic logic [ELEM_W-1:0] sat32(input logic signed [63:0] v);
        logic [ELEM_W-1:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'h7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'h80000000;
        end else begin
            r = v[ELEM_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== design/euler_yxz_model_normal_matrix_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Euler Y-X-Z model and normal matrix generator
// Builds R = Ry * Rx * Rz from three binary angles and emits the 4x4 model
// matrix columns followed by the 3x3 normal matrix columns in Q16.16.
// ----------------------------------------------------------------------------
// Each input transaction yields seven output transactions, one column per
// cycle while i_stall is low: model columns 0..2 (rotation times scale),
// model column 3 (the translation with w = 1), then normal columns 0..2
// (rotation times the reciprocal of scale, with a saturation flag). The
// seven-column output serializer limits the input rate: o_stall rises when
// stage 8 is full and the output buffer cannot yet take its result. The
// datapath has eight pipeline stages (index, quarter-wave table read,
// sine/cosine sign, two product levels, sums, reciprocal finish, scale
// products) plus the output buffer. The three reciprocals use a restoring
// divider spread over five of those stages, five quotient bits per stage.
// ----------------------------------------------------------------------------
module euler_yxz_model_normal_matrix_top #(
    parameter int ANGLE_BITS      = 16,
    parameter int FRAC_BITS       = 16,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [eyxz_pkg::ANGLE_W-1:0]          i_angle_x,
    input  logic [eyxz_pkg::ANGLE_W-1:0]          i_angle_y,
    input  logic [eyxz_pkg::ANGLE_W-1:0]          i_angle_z,
    input  logic signed [eyxz_pkg::SCALE_W-1:0]   i_scale_x,
    input  logic signed [eyxz_pkg::SCALE_W-1:0]   i_scale_y,
    input  logic signed [eyxz_pkg::SCALE_W-1:0]   i_scale_z,
    input  logic signed [eyxz_pkg::TRANS_W-1:0]   i_trans_x,
    input  logic signed [eyxz_pkg::TRANS_W-1:0]   i_trans_y,
    input  logic signed [eyxz_pkg::TRANS_W-1:0]   i_trans_z,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic                                  o_matrix_kind,
    output logic [1:0]                            o_column_index,
    output logic signed [eyxz_pkg::ELEM_W-1:0]    o_elem_row0,
    output logic signed [eyxz_pkg::ELEM_W-1:0]    o_elem_row1,
    output logic signed [eyxz_pkg::ELEM_W-1:0]    o_elem_row2,
    output logic [eyxz_pkg::ROW3_W-1:0]           o_elem_row3,
    output logic                                  o_recip_saturated,
    output logic                                  o_last_column
);
    import eyxz_pkg::*;

    localparam int AB     = ANGLE_BITS;
    localparam int F      = FRAC_BITS;
    localparam int T      = SINE_TABLE_BITS;
    localparam int TAB_N  = 1 << T;
    localparam int REM    = AB - 2;
    localparam int SH     = (REM >= T) ? REM - T : 0;
    localparam int LSH    = (REM < T) ? T - REM : 0;
    localparam int IW     = REM + T + 2;
    localparam int SW     = F + 2;
    localparam int RW     = F + 3;
    localparam int MPW    = SCALE_W + RW;
    localparam int NPW    = RECIP_W + RW;
    localparam int NSTAGE = 8;

    localparam logic [IW-1:0] IDX_HALF =
        (SH > 0) ? (IW'(1) << ((SH > 0) ? SH - 1 : 0)) : '0;
    localparam logic signed [2*SW-1:0] MQ_HALF = (2*SW)'(1) << (F - 1);
    localparam logic signed [63:0] M_HALF =
        (F > 8) ? (64'sd1 <<< ((F > 8) ? F - 9 : 0)) : 64'sd0;
    localparam logic signed [63:0] N_HALF = 64'sd1 <<< (F - 1);

    typedef logic [F:0] t_rom [0:TAB_N];

    // Quarter-wave sine table, built at elaboration by a Taylor series.
    function automatic t_rom build_rom();
        t_rom               rom;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] val;
        for (int i = 0; i <= TAB_N; i++) begin
            x    = (64'(i) * HALF_PI_Q30) >> T;
            x2   = (x * x) >> 30;
            term = x;
            sum  = $signed(x);
            for (int k = 1; k <= 10; k++) begin
                term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
                if ((k & 1) == 1) begin
                    sum = sum - $signed(term);
                end else begin
                    sum = sum + $signed(term);
                end
            end
            if (sum < 0) begin
                sum = 64'sd0;
            end
            val = (sum + (64'sd1 <<< (29 - F))) >>> (30 - F);
            if (val > (64'sd1 <<< F)) begin
                val = 64'sd1 <<< F;
            end
            rom[i] = val[F:0];
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

    // Table index from the angle bits below the quadrant.
    function automatic logic [T:0] tab_index(input logic [AB-1:0] a);
        logic [IW-1:0] low;
        logic [IW-1:0] idx;
        low = IW'(a[REM-1:0]);
        if (REM >= T) begin
            idx = (low + IDX_HALF) >> SH;
        end else begin
            idx = low << LSH;
        end
        return idx[T:0];
    endfunction

    // Rounded Q product of two sine/cosine-range values.
    function automatic logic signed [SW-1:0] mq(input logic signed [SW-1:0] a,
                                                input logic signed [SW-1:0] b);
        logic signed [2*SW-1:0] p;
        p = (2*SW)'(a * b) + MQ_HALF;
        return SW'(p >>> F);
    endfunction

    // Flow control: the whole pipeline moves when stage 8 can drain.
    logic en;
    logic out_take;
    logic ob_free;

    logic [NSTAGE:1] r_vld;
    t_side           r_side [1:NSTAGE];
    t_side           n_side;

    // Stage 1: table indices, quadrants and divider setup.
    logic [AB-1:0] n_ang  [3];
    logic [T:0]    r1_idx [3];
    logic [T:0]    r1_ridx[3];
    logic [1:0]    r1_quad[3];
    t_div          r_div  [1:6][3];
    t_div          n_div  [1:6][3];

    // Stage 2: raw table values.
    logic [F:0] r2_d   [3];
    logic [F:0] r2_r   [3];
    logic [1:0] r2_quad[3];

    // Stage 3: signed sine and cosine (lane 0 = y, 1 = x, 2 = z).
    logic signed [SW-1:0] r3_sn[3];
    logic signed [SW-1:0] r3_cs[3];
    logic signed [SW-1:0] n3_sn[3];
    logic signed [SW-1:0] n3_cs[3];

    // Stage 4: first product level.
    logic signed [SW-1:0] r4_c1c3, r4_s1s2, r4_c2s3, r4_c1s2, r4_c3s1;
    logic signed [SW-1:0] r4_c1s3, r4_c2c3, r4_s1s3, r4_c2s1, r4_c1c2;
    logic signed [SW-1:0] r4_s2, r4_s3;

    // Stage 5: second product level.
    logic signed [SW-1:0] r5_a, r5_b, r5_c, r5_d;
    logic signed [SW-1:0] r5_c1c3, r5_c2s3, r5_c3s1, r5_c1s3;
    logic signed [SW-1:0] r5_c2c3, r5_s1s3, r5_c2s1, r5_c1c2, r5_s2;

    // Stages 6 and 7: rotation, then reciprocals.
    logic signed [RW-1:0]      r6_rot  [3][3];
    logic signed [RW-1:0]      n6_rot  [3][3];
    logic signed [RW-1:0]      r7_rot  [3][3];
    logic signed [RECIP_W-1:0] r7_recip[3];
    logic                      r7_rsat [3];
    logic signed [RECIP_W-1:0] n7_recip[3];
    logic                      n7_rsat [3];

    // Stage 8: scale and reciprocal products.
    logic signed [MPW-1:0] r8_mprod[3][3];
    logic signed [NPW-1:0] r8_nprod[3][3];
    logic                  r8_rsat [3];

    // Output buffer and column counter.
    logic              r_ob_v;
    logic [2:0]        r_col;
    logic [ELEM_W-1:0] r_ob_model[3][3];
    logic [ELEM_W-1:0] r_ob_norm [3][3];
    logic [ELEM_W-1:0] r_ob_trans[3];
    logic              r_ob_sat  [3];
    logic [ELEM_W-1:0] n_ob_model[3][3];
    logic [ELEM_W-1:0] n_ob_norm [3][3];

    assign out_take = r_ob_v && !i_stall;
    assign ob_free  = !r_ob_v || (out_take && (r_col == COL_LAST));
    assign en       = !r_vld[NSTAGE] || ob_free;
    assign o_stall  = !en;

    // Input side: angles reduced to ANGLE_BITS, divider lanes initialized and stepped.
    always_comb begin
        n_ang[0] = AB'({{AB{1'b0}}, i_angle_y});
        n_ang[1] = AB'({{AB{1'b0}}, i_angle_x});
        n_ang[2] = AB'({{AB{1'b0}}, i_angle_z});
        n_side.scale[0] = i_scale_x;
        n_side.scale[1] = i_scale_y;
        n_side.scale[2] = i_scale_z;
        n_side.trans[0] = i_trans_x;
        n_side.trans[1] = i_trans_y;
        n_side.trans[2] = i_trans_z;
        for (int l = 0; l < 3; l++) begin
            n_div[1][l].zero = (n_side.scale[l] == '0);
            n_div[1][l].neg  = n_side.scale[l][SCALE_W-1];
            n_div[1][l].den  = n_div[1][l].neg ? DEN_W'(-n_side.scale[l])
                                               : DEN_W'(n_side.scale[l]);
            n_div[1][l].num  = NUM_ONE + NUM_W'(n_div[1][l].den >> 1);
            n_div[1][l].rem  = '0;
            n_div[1][l].quo  = '0;
        end
        for (int st = 1; st < 6; st++) begin
            for (int l = 0; l < 3; l++) begin
                n_div[st+1][l] = div_step(r_div[st][l],
                                          NUM_W - 1 - (st - 1) * DIV_BITS);
            end
        end
    end

    // Sign and swap of the table values by quadrant.
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            case (r2_quad[l])
                QUAD_0: begin
                    n3_sn[l] = $signed({1'b0, r2_d[l]});
                    n3_cs[l] = $signed({1'b0, r2_r[l]});
                end
                QUAD_1: begin
                    n3_sn[l] = $signed({1'b0, r2_r[l]});
                    n3_cs[l] = -$signed({1'b0, r2_d[l]});
                end
                QUAD_2: begin
                    n3_sn[l] = -$signed({1'b0, r2_d[l]});
                    n3_cs[l] = -$signed({1'b0, r2_r[l]});
                end
                default: begin
                    n3_sn[l] = -$signed({1'b0, r2_r[l]});
                    n3_cs[l] = $signed({1'b0, r2_d[l]});
                end
            endcase
        end
    end

    // Rotation sums and reciprocal finishing.
    always_comb begin
        logic signed [NUM_W:0] qs;
        n6_rot[0][0] = RW'(r5_c1c3) + RW'(r5_a);
        n6_rot[0][1] = RW'(r5_c2s3);
        n6_rot[0][2] = RW'(r5_b) - RW'(r5_c3s1);
        n6_rot[1][0] = RW'(r5_c) - RW'(r5_c1s3);
        n6_rot[1][1] = RW'(r5_c2c3);
        n6_rot[1][2] = RW'(r5_d) + RW'(r5_s1s3);
        n6_rot[2][0] = RW'(r5_c2s1);
        n6_rot[2][1] = -RW'(r5_s2);
        n6_rot[2][2] = RW'(r5_c1c2);
        for (int l = 0; l < 3; l++) begin
            qs = r_div[6][l].neg ? -$signed({1'b0, r_div[6][l].quo})
                                 : $signed({1'b0, r_div[6][l].quo});
            if (r_div[6][l].zero) begin
                n7_recip[l] = RECIP_MAX;
                n7_rsat[l]  = 1'b1;
            end else if (qs > (NUM_W+1)'(RECIP_MAX)) begin
                n7_recip[l] = RECIP_MAX;
                n7_rsat[l]  = 1'b1;
            end else if (qs < (NUM_W+1)'(RECIP_MIN)) begin
                n7_recip[l] = RECIP_MIN;
                n7_rsat[l]  = 1'b1;
            end else begin
                n7_recip[l] = qs[RECIP_W-1:0];
                n7_rsat[l]  = 1'b0;
            end
        end
    end

    // Final rounding and saturation into the output buffer.
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            for (int i = 0; i < 3; i++) begin
                n_ob_model[j][i] = sat32((64'(r8_mprod[j][i]) + M_HALF) >>> (F - 8));
                n_ob_norm[j][i]  = sat32((64'(r8_nprod[j][i]) + N_HALF) >>> F);
            end
        end
    end

    // Valid bits of the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTAGE-1:1], i_valid};
        end
    end

    // Pipeline datapath registers.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[1] <= n_side;
            for (int k = 2; k <= NSTAGE; k++) begin
                r_side[k] <= r_side[k-1];
            end
            for (int st = 1; st <= 6; st++) begin
                for (int l = 0; l < 3; l++) begin
                    r_div[st][l] <= n_div[st][l];
                end
            end
            for (int l = 0; l < 3; l++) begin
                r1_idx[l]  <= tab_index(n_ang[l]);
                r1_ridx[l] <= (T+1)'(TAB_N) - tab_index(n_ang[l]);
                r1_quad[l] <= n_ang[l][AB-1:AB-2];
                r2_d[l]    <= SINE_ROM[r1_idx[l]];
                r2_r[l]    <= SINE_ROM[r1_ridx[l]];
                r2_quad[l] <= r1_quad[l];
                r3_sn[l]   <= n3_sn[l];
                r3_cs[l]   <= n3_cs[l];
            end

            r4_c1c3 <= mq(r3_cs[0], r3_cs[2]);
            r4_s1s2 <= mq(r3_sn[0], r3_sn[1]);
            r4_c2s3 <= mq(r3_cs[1], r3_sn[2]);
            r4_c1s2 <= mq(r3_cs[0], r3_sn[1]);
            r4_c3s1 <= mq(r3_cs[2], r3_sn[0]);
            r4_c1s3 <= mq(r3_cs[0], r3_sn[2]);
            r4_c2c3 <= mq(r3_cs[1], r3_cs[2]);
            r4_s1s3 <= mq(r3_sn[0], r3_sn[2]);
            r4_c2s1 <= mq(r3_cs[1], r3_sn[0]);
            r4_c1c2 <= mq(r3_cs[0], r3_cs[1]);
            r4_s2   <= r3_sn[1];
            r4_s3   <= r3_sn[2];

            r5_a    <= mq(r4_s1s2, r4_s3);
            r5_b    <= mq(r4_c1s2, r4_s3);
            r5_c    <= mq(r4_c3s1, r4_s2);
            r5_d    <= mq(r4_c1c3, r4_s2);
            r5_c1c3 <= r4_c1c3;
            r5_c2s3 <= r4_c2s3;
            r5_c3s1 <= r4_c3s1;
            r5_c1s3 <= r4_c1s3;
            r5_c2c3 <= r4_c2c3;
            r5_s1s3 <= r4_s1s3;
            r5_c2s1 <= r4_c2s1;
            r5_c1c2 <= r4_c1c2;
            r5_s2   <= r4_s2;

            for (int j = 0; j < 3; j++) begin
                r7_recip[j] <= n7_recip[j];
                r7_rsat[j]  <= n7_rsat[j];
                r8_rsat[j]  <= r7_rsat[j];
                for (int i = 0; i < 3; i++) begin
                    r6_rot[j][i]   <= n6_rot[j][i];
                    r7_rot[j][i]   <= r6_rot[j][i];
                    r8_mprod[j][i] <= MPW'($signed(r_side[7].scale[j]) * r7_rot[j][i]);
                    r8_nprod[j][i] <= NPW'(r7_recip[j] * r7_rot[j][i]);
                end
            end
        end
    end

    // Output buffer control: seven columns per transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_v <= 1'b0;
            r_col  <= '0;
        end else begin
            if (out_take) begin
                if (r_col == COL_LAST) begin
                    r_ob_v <= 1'b0;
                    r_col  <= '0;
                end else begin
                    r_col <= r_col + 3'd1;
                end
            end
            if (en && r_vld[NSTAGE]) begin
                r_ob_v <= 1'b1;
                r_col  <= '0;
            end
        end
    end

    // Output buffer payload.
    always_ff @(posedge i_clk) begin
        if (en && r_vld[NSTAGE]) begin
            for (int j = 0; j < 3; j++) begin
                r_ob_trans[j] <= r_side[NSTAGE].trans[j];
                r_ob_sat[j]   <= r8_rsat[j];
                for (int i = 0; i < 3; i++) begin
                    r_ob_model[j][i] <= n_ob_model[j][i];
                    r_ob_norm[j][i]  <= n_ob_norm[j][i];
                end
            end
        end
    end

    // Column select for the output transaction.
    always_comb begin
        logic [1:0] nj;
        nj                = 2'(r_col - COL_NORM0);
        o_valid           = r_ob_v;
        o_last_column     = (r_col == COL_LAST);
        o_elem_row3       = '0;
        o_recip_saturated = 1'b0;
        if (r_col < COL_TRANS) begin
            o_matrix_kind  = 1'b0;
            o_column_index = r_col[1:0];
            o_elem_row0    = r_ob_model[r_col[1:0]][0];
            o_elem_row1    = r_ob_model[r_col[1:0]][1];
            o_elem_row2    = r_ob_model[r_col[1:0]][2];
        end else if (r_col == COL_TRANS) begin
            o_matrix_kind  = 1'b0;
            o_column_index = r_col[1:0];
            o_elem_row0    = r_ob_trans[0];
            o_elem_row1    = r_ob_trans[1];
            o_elem_row2    = r_ob_trans[2];
            o_elem_row3    = ROW3_ONE;
        end else begin
            o_matrix_kind     = 1'b1;
            o_column_index    = nj;
            o_elem_row0       = r_ob_norm[nj][0];
            o_elem_row1       = r_ob_norm[nj][1];
            o_elem_row2       = r_ob_norm[nj][2];
            o_recip_saturated = r_ob_sat[nj];
        end
    end

    // Checks on the column sequencer.
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= COL_LAST)
        else $error("column counter out of range");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ob_v && i_stall) |=> (r_ob_v && $stable(r_col)))
        else $error("output column moved while stalled");

    a_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_take && r_col == COL_LAST) |=> (!r_ob_v || r_col == '0))
        else $error("sequence did not restart after the last column");

    a_sat_normal_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_matrix_kind) |-> !o_recip_saturated)
        else $error("saturation flag on a model column");

endmodule
